// File: sv/puct_pkg.sv
// Package for the prescaled up-counter timer.
// Holds the command codes, register offsets, config indexes and the state type.
// Used by the channel interfaces and the top level.
package puct_pkg;

   localparam int CmdWidth    = 2;
   localparam int OffsetWidth = 8;
   localparam int DataWidth   = 32;
   localparam int CyclesWidth = 16;
   localparam int HzWidth     = 28;
   localparam int CsrIdxWidth = 2;
   localparam int AccWidth    = 64;
   localparam int DenWidth    = 60;
   localparam int MplWidth    = 33;
   localparam int TcWidth     = 44;

   typedef enum logic [CmdWidth-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   localparam logic [OffsetWidth-1:0] OFF_CR1   = 8'h00;
   localparam logic [OffsetWidth-1:0] OFF_CR2   = 8'h04;
   localparam logic [OffsetWidth-1:0] OFF_SMCR  = 8'h08;
   localparam logic [OffsetWidth-1:0] OFF_DIER  = 8'h0C;
   localparam logic [OffsetWidth-1:0] OFF_SR    = 8'h10;
   localparam logic [OffsetWidth-1:0] OFF_EGR   = 8'h14;
   localparam logic [OffsetWidth-1:0] OFF_CCMR1 = 8'h18;
   localparam logic [OffsetWidth-1:0] OFF_CCMR2 = 8'h1C;
   localparam logic [OffsetWidth-1:0] OFF_CCER  = 8'h20;
   localparam logic [OffsetWidth-1:0] OFF_CNT   = 8'h24;
   localparam logic [OffsetWidth-1:0] OFF_PSC   = 8'h28;
   localparam logic [OffsetWidth-1:0] OFF_ARR   = 8'h2C;
   localparam logic [OffsetWidth-1:0] OFF_CCR1  = 8'h34;
   localparam logic [OffsetWidth-1:0] OFF_CCR2  = 8'h38;
   localparam logic [OffsetWidth-1:0] OFF_CCR3  = 8'h3C;
   localparam logic [OffsetWidth-1:0] OFF_CCR4  = 8'h40;

   localparam logic [CsrIdxWidth-1:0] CSR_TIMER_HZ = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BUS_HZ   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_CLK_EN   = 2'd2;

   localparam logic [HzWidth-1:0]   DEFAULT_HZ     = 28'd16000000;
   localparam logic [DataWidth-1:0] TOP_WHEN_ZERO  = 32'h0000FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_ADV1,
      ST_ADV2,
      ST_FIN
   } state_type;

endpackage

// File: sv/puct_req_if.sv
// Request channel of the timer: command word with valid/ready.
// Depends on puct_pkg for the field widths.
interface puct_req_if;
   import puct_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CmdWidth-1:0]    command;
   logic [OffsetWidth-1:0] register_offset;
   logic [DataWidth-1:0]   write_data;
   logic [CyclesWidth-1:0] tick_cycles;
   modport source (output valid, command, register_offset, write_data, tick_cycles,
                   input ready);
   modport sink (input valid, command, register_offset, write_data, tick_cycles,
                 output ready);
endinterface

// File: sv/puct_rsp_if.sv
// Response channel of the timer: read data and interrupt level with valid/ready.
// Depends on puct_pkg for the field widths.
interface puct_rsp_if;
   import puct_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] read_data;
   logic                 irq_pending;
   modport source (output valid, read_data, irq_pending, input ready);
   modport sink (input valid, read_data, irq_pending, output ready);
endinterface

// File: sv/puct_csr_if.sv
// Configuration write channel of the timer: register index and data.
// Depends on puct_pkg for the field widths.
interface puct_csr_if;
   import puct_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CsrIdxWidth-1:0] reg_index;
   logic [HzWidth-1:0]     wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: sv/prescaled_up_counter_timer.sv
// Top level of the prescaled up-counter timer: register bank, shift-add
// multiplier, radix-2 divider and counter update. Depends on puct_pkg and the
// three channel interfaces.
//
// Usage: each request word is a register read or write, a no-op or a tick of
// a number of bus cycles; each produces exactly one response word carrying the
// read data (zero unless a read) and the interrupt level after the request.
// The csr channel sets the timer clock, the bus clock and the clock gate and is
// always ready; it is to be written by the user only while the timer is idle,
// which the block does not enforce. A read, write or disabled tick passes from
// acceptance through the execute and finish states to the response register.
// An enabled tick runs a bit-serial multiply and a bit-serial divide, then the
// counter update states ADV1 and ADV2, plus another divide when the remaining
// advance carries the count past the top. One request is processed at a time.
// The response sits in an output register; the next request is accepted while
// it waits, and a finished request holds in its last state until the receiver
// takes the previous response.
// Reset zeroes the register bank, accumulator and response valid except the
// reload value (all ones), sets both clocks to 16 MHz and opens the clock gate.
module prescaled_up_counter_timer (
   input logic         clock,
   input logic         reset,
   puct_req_if.sink    req_bus,
   puct_rsp_if.source  rsp_bus,
   puct_csr_if.sink    csr_bus
);
   import puct_pkg::*;

   state_type state_ff, state_in;

   logic [HzWidth-1:0]   tclk_ff, tclk_in, bclk_ff, bclk_in;
   logic                 clken_ff, clken_in;
   logic [DataWidth-1:0] cr1_ff, cr1_in, cr2_ff, cr2_in, smcr_ff, smcr_in;
   logic [DataWidth-1:0] dier_ff, dier_in, sr_ff, sr_in;
   logic [DataWidth-1:0] ccmr1_ff, ccmr1_in, ccmr2_ff, ccmr2_in, ccer_ff, ccer_in;
   logic [DataWidth-1:0] cnt_ff, cnt_in, psc_ff, psc_in, arr_ff, arr_in;
   logic [DataWidth-1:0] ccr_ff [4];
   logic [DataWidth-1:0] ccr_in [4];
   logic [AccWidth-1:0]  acc_ff, acc_in;

   cmd_type                item_cmd_ff, item_cmd_in;
   logic [OffsetWidth-1:0] item_off_ff, item_off_in;
   logic [DataWidth-1:0]   item_data_ff, item_data_in;
   logic [CyclesWidth-1:0] item_cyc_ff, item_cyc_in;

   logic [MplWidth-1:0]    mpl_ff, mpl_in;
   logic [DenWidth-1:0]    mcand_ff, mcand_in;
   logic [CyclesWidth-1:0] cyc_sh_ff, cyc_sh_in;
   logic [TcWidth-1:0]     tc_ff, tc_in;
   logic [DenWidth-1:0]    den_ff, den_in;
   logic [DenWidth-1:0]    rem_ff, rem_in;
   logic [AccWidth-1:0]    q_ff, q_in;
   logic [5:0]             step_ff, step_in;
   logic                   mod_ff, mod_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_irq_ff, rsp_irq_in;
   logic [DataWidth-1:0] rd_ff, rd_in;

   logic                 req_fire;
   logic                 rsp_load;
   logic [DenWidth:0]    div_sh;
   logic [DenWidth:0]    div_diff;
   logic                 div_ge;
   logic [DataWidth:0]   top;
   logic [DataWidth:0]   to_wrap;
   logic [DataWidth-1:0] rd_val;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign req_fire        = req_bus.valid & req_bus.ready;
   assign csr_bus.ready   = 1'b1;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.read_data   = rsp_data_ff;
   assign rsp_bus.irq_pending = rsp_irq_ff;

   assign div_sh   = {rem_ff, q_ff[AccWidth-1]};
   assign div_diff = div_sh - {1'b0, den_ff};
   assign div_ge   = (div_sh >= {1'b0, den_ff});
   assign top      = (arr_ff != '0) ? {1'b0, arr_ff} : {1'b0, TOP_WHEN_ZERO};
   assign to_wrap  = top - {1'b0, cnt_ff} + 33'd1;
   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      case (item_off_ff)
         OFF_CR1:   rd_val = cr1_ff;
         OFF_CR2:   rd_val = cr2_ff;
         OFF_SMCR:  rd_val = smcr_ff;
         OFF_DIER:  rd_val = dier_ff;
         OFF_SR:    rd_val = sr_ff;
         OFF_CCMR1: rd_val = ccmr1_ff;
         OFF_CCMR2: rd_val = ccmr2_ff;
         OFF_CCER:  rd_val = ccer_ff;
         OFF_CNT:   rd_val = cnt_ff;
         OFF_PSC:   rd_val = psc_ff;
         OFF_ARR:   rd_val = arr_ff;
         OFF_CCR1:  rd_val = ccr_ff[0];
         OFF_CCR2:  rd_val = ccr_ff[1];
         OFF_CCR3:  rd_val = ccr_ff[2];
         OFF_CCR4:  rd_val = ccr_ff[3];
         default:   rd_val = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      tclk_in = tclk_ff;   bclk_in = bclk_ff;   clken_in = clken_ff;
      cr1_in = cr1_ff;     cr2_in = cr2_ff;     smcr_in = smcr_ff;
      dier_in = dier_ff;   sr_in = sr_ff;
      ccmr1_in = ccmr1_ff; ccmr2_in = ccmr2_ff; ccer_in = ccer_ff;
      cnt_in = cnt_ff;     psc_in = psc_ff;     arr_in = arr_ff;
      ccr_in = ccr_ff;     acc_in = acc_ff;
      item_cmd_in = item_cmd_ff;   item_off_in = item_off_ff;
      item_data_in = item_data_ff; item_cyc_in = item_cyc_ff;
      mpl_in = mpl_ff;     mcand_in = mcand_ff; cyc_sh_in = cyc_sh_ff;
      tc_in = tc_ff;       den_in = den_ff;     rem_in = rem_ff;
      q_in = q_ff;         step_in = step_ff;   mod_in = mod_ff;
      rd_in = rd_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_data_in = rsp_data_ff;
      rsp_irq_in = rsp_irq_ff;

      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_TIMER_HZ: tclk_in = csr_bus.wdata;
            CSR_BUS_HZ:   bclk_in = csr_bus.wdata;
            CSR_CLK_EN:   clken_in = csr_bus.wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_cmd_in  = cmd_type'(req_bus.command);
               item_off_in  = req_bus.register_offset;
               item_data_in = req_bus.write_data;
               item_cyc_in  = req_bus.tick_cycles;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rd_in    = '0;
            state_in = ST_FIN;
            case (item_cmd_ff)
               CMD_READ: rd_in = rd_val;
               CMD_WRITE: begin
                  case (item_off_ff)
                     OFF_CR1:   cr1_in = item_data_ff;
                     OFF_CR2:   cr2_in = item_data_ff;
                     OFF_SMCR:  smcr_in = item_data_ff;
                     OFF_DIER:  dier_in = item_data_ff;
                     OFF_SR:    sr_in = sr_ff & ~item_data_ff;
                     OFF_EGR: begin
                        if (item_data_ff[0]) begin
                           cnt_in   = '0;
                           sr_in[0] = 1'b1;
                        end
                     end
                     OFF_CCMR1: ccmr1_in = item_data_ff;
                     OFF_CCMR2: ccmr2_in = item_data_ff;
                     OFF_CCER:  ccer_in = item_data_ff;
                     OFF_CNT:   cnt_in = item_data_ff;
                     OFF_PSC:   psc_in = item_data_ff;
                     OFF_ARR:   arr_in = item_data_ff;
                     OFF_CCR1:  ccr_in[0] = item_data_ff;
                     OFF_CCR2:  ccr_in[1] = item_data_ff;
                     OFF_CCR3:  ccr_in[2] = item_data_ff;
                     OFF_CCR4:  ccr_in[3] = item_data_ff;
                     default: ;
                  endcase
               end
               CMD_TICK: begin
                  if (cr1_ff[0] && clken_ff && bclk_ff != '0) begin
                     // Divisor and dividend are built together, one
                     // multiplier bit per cycle.
                     mpl_in    = {1'b0, psc_ff} + 33'd1;
                     mcand_in  = DenWidth'(bclk_ff);
                     cyc_sh_in = item_cyc_ff;
                     tc_in     = TcWidth'(tclk_ff);
                     den_in    = '0;
                     q_in      = acc_ff;
                     step_in   = '0;
                     state_in  = ST_MUL;
                  end
               end
               default: ;
            endcase
         end
         ST_MUL: begin
            if (mpl_ff[0]) den_in = den_ff + mcand_ff;
            if (cyc_sh_ff[0]) q_in = q_ff + AccWidth'(tc_ff);
            mcand_in  = {mcand_ff[DenWidth-2:0], 1'b0};
            mpl_in    = {1'b0, mpl_ff[MplWidth-1:1]};
            tc_in     = {tc_ff[TcWidth-2:0], 1'b0};
            cyc_sh_in = {1'b0, cyc_sh_ff[CyclesWidth-1:1]};
            step_in   = step_ff + 6'd1;
            if (step_ff == 6'(MplWidth - 1)) begin
               rem_in   = '0;
               step_in  = '0;
               mod_in   = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? div_diff[DenWidth-1:0] : div_sh[DenWidth-1:0];
            q_in    = {q_ff[AccWidth-2:0], div_ge};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(AccWidth - 1)) begin
               if (mod_ff) begin
                  cnt_in   = rem_in[DataWidth-1:0];
                  state_in = ST_FIN;
               end else begin
                  acc_in   = AccWidth'(rem_in);
                  state_in = ST_ADV1;
               end
            end
         end
         ST_ADV1: begin
            if (q_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               if ({1'b0, cnt_ff} >= top) begin
                  cnt_in   = '0;
                  sr_in[0] = 1'b1;
                  q_in     = q_ff - 64'd1;
               end
               state_in = ST_ADV2;
            end
         end
         ST_ADV2: begin
            if (q_ff < AccWidth'(to_wrap)) begin
               cnt_in   = cnt_ff + q_ff[DataWidth-1:0];
               state_in = ST_FIN;
            end else begin
               // Past the first wrap the count is the remainder by the period.
               sr_in[0] = 1'b1;
               q_in     = q_ff - AccWidth'(to_wrap);
               den_in   = DenWidth'(top) + 60'd1;
               rem_in   = '0;
               step_in  = '0;
               mod_in   = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_ff;
               rsp_irq_in   = sr_ff[0] & dier_ff[0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tclk_ff <= DEFAULT_HZ;  bclk_ff <= DEFAULT_HZ;  clken_ff <= 1'b1;
         cr1_ff <= '0;   cr2_ff <= '0;   smcr_ff <= '0;  dier_ff <= '0;
         sr_ff <= '0;    ccmr1_ff <= '0; ccmr2_ff <= '0; ccer_ff <= '0;
         cnt_ff <= '0;   psc_ff <= '0;   arr_ff <= '1;
         ccr_ff <= '{default: '0};
         acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tclk_ff <= tclk_in;  bclk_ff <= bclk_in;  clken_ff <= clken_in;
         cr1_ff <= cr1_in;    cr2_ff <= cr2_in;    smcr_ff <= smcr_in;
         dier_ff <= dier_in;  sr_ff <= sr_in;
         ccmr1_ff <= ccmr1_in; ccmr2_ff <= ccmr2_in; ccer_ff <= ccer_in;
         cnt_ff <= cnt_in;    psc_ff <= psc_in;    arr_ff <= arr_in;
         ccr_ff <= ccr_in;
         acc_ff <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff <= item_cmd_in;   item_off_ff <= item_off_in;
      item_data_ff <= item_data_in; item_cyc_ff <= item_cyc_in;
      mpl_ff <= mpl_in;   mcand_ff <= mcand_in; cyc_sh_ff <= cyc_sh_in;
      tc_ff <= tc_in;     den_ff <= den_in;     rem_ff <= rem_in;
      q_ff <= q_in;       step_ff <= step_in;   mod_ff <= mod_in;
      rd_ff <= rd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff <= rsp_irq_in;
   end

   // The partial remainder always stays below the divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder reached the divisor");

   // The response carries the interrupt level seen when it was loaded.
   a_irq_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_irq_ff == ($past(sr_ff[0]) & $past(dier_ff[0]))))
      else $error("response interrupt level does not match status");

   // A pending response is never overwritten by a finishing request.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending response was lost");

endmodule
